/* hw/rtl/virtual_timer_pool_macros.svh */
// Assertion macros for the virtual timer pool checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef VIRTUAL_TIMER_POOL_MACROS_SVH
`define VIRTUAL_TIMER_POOL_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VTP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("virtual_timer_pool: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define VTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("virtual_timer_pool: next-cycle check failed");

`endif

/* hw/rtl/vtp_pkg.sv */
// Shared types and constants for the virtual timer pool.
// Used by virtual_timer_pool and vtp_checker; no dependencies.
package vtp_pkg;

  // Request codes carried in in_tuser; the unused code acts as an update.
  localparam logic [1:0] FUNC_CREATE  = 2'd0;
  localparam logic [1:0] FUNC_DESTROY = 2'd1;
  localparam logic [1:0] FUNC_UPDATE  = 2'd2;

  typedef enum logic [1:0] {
    KIND_EXPIRED = 2'd0,
    KIND_CREATE  = 2'd1,
    KIND_DESTROY = 2'd2,
    KIND_UPDATE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_t;

  // At most this many expiry words per request
  localparam int MAX_EXPIRY = 8;
  localparam int EXP_CNT_W  = 4;

  localparam int USER_W = 2;

  // Input word layout
  localparam int IN_DATA_W       = 72;
  localparam int IN_ELAPSED_LSB  = 0;
  localparam int IN_PERIOD_LSB   = 32;
  localparam int IN_PERIODIC_BIT = 64;
  localparam int IN_ID_LSB       = 65;

  // Output word layout
  localparam int OUT_DATA_W   = 40;
  localparam int OUT_SLOT_LSB = 0;
  localparam int OUT_OK_BIT   = 3;
  localparam int OUT_DL_LSB   = 4;
  localparam int OUT_DL_MSB   = 35;
  localparam int OUT_DV_BIT   = 36;
  localparam int OUT_PAD_W    = 3;

endpackage

/* hw/rtl/virtual_timer_pool.sv */
// Virtual timer pool: running/periodic flags in flops, periods and counts in
// one synchronous RAM swept slot by slot. Depends on vtp_pkg.
//
//   channel | dir | tdata (low bit up)                          | tuser | tlast
//   in_     | in  | elapsed, period, periodic, timer_id         | func  | -
//   out_    | out | slot, create_ok, next_deadline, dl_valid    | kind  | last
//
// Create and update sweep every slot through the RAM: one read per cycle while
// the output is not stalled; each slot is updated and written back once its
// read data is registered. Destroy skips the sweep and goes straight to the
// final word. A full output register holds the sweep on an expiry.
// Reset (rst_n low, synchronous) stops all timers; the RAM needs no clearing.
module virtual_timer_pool #(
  parameter int NUM_TIMERS = 8,
  parameter int TICK_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // elapsed_ticks[31:0], period_ticks[63:32], periodic[64], timer_id[67:65]
  input  logic [vtp_pkg::IN_DATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [vtp_pkg::USER_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // slot[2:0], create_ok[3], next_deadline[35:4], deadline_valid[36]
  output logic [vtp_pkg::OUT_DATA_W-1:0] out_tdata,
  // kind[1:0]
  output logic [vtp_pkg::USER_W-1:0]     out_tuser,
  output logic                           out_tlast
);
  import vtp_pkg::*;

  localparam int TW    = TICK_WIDTH;
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam logic [TW-1:0]    TICK_MAX   = '1;
  localparam logic [31:0]      TICK_MAX32 = 32'(TICK_MAX);
  localparam logic [CNT_W-1:0] END_CNT    = CNT_W'(NUM_TIMERS);

  // Input word fields
  logic [31:0] in_elapsed;
  logic [31:0] in_period;
  logic        in_periodic;
  logic [2:0]  in_id;
  logic [TW-1:0] in_ticks;

  assign in_elapsed  = in_tdata[IN_ELAPSED_LSB +: 32];
  assign in_period   = in_tdata[IN_PERIOD_LSB +: 32];
  assign in_periodic = in_tdata[IN_PERIODIC_BIT];
  assign in_id       = in_tdata[IN_ID_LSB +: 3];
  // period + 1, saturating so a loaded timer never holds zero
  assign in_ticks = (in_period >= TICK_MAX32) ? TICK_MAX : (in_period[TW-1:0] + TW'(1));

  // Control registers
  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        rd_cnt_r, rd_cnt_nxt;
  logic                    p_vld_r, p_vld_nxt;
  logic [NUM_TIMERS-1:0]   running_r, running_nxt;
  logic [NUM_TIMERS-1:0]   periodic_r, periodic_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Per-request and sweep registers
  logic [1:0]              func_r, func_nxt;
  logic                    apply_r, apply_nxt;
  logic [TW-1:0]           el_r, el_nxt;
  logic [TW-1:0]           ticks_r, ticks_nxt;
  logic                    per_r, per_nxt;
  logic [2:0]              id_r, id_nxt;
  logic [IDX_W-1:0]        p_idx_r, p_idx_nxt;
  logic [EXP_CNT_W-1:0]    exp_cnt_r, exp_cnt_nxt;
  logic [TW-1:0]           min_r, min_nxt;
  logic                    any_r, any_nxt;
  logic                    free_found_r, free_found_nxt;
  logic [IDX_W-1:0]        free_idx_r, free_idx_nxt;

  // Output register
  kind_t                   kind_r, kind_nxt;
  logic [2:0]              slot_r, slot_nxt;
  logic                    ok_r, ok_nxt;
  logic [31:0]             dl_r, dl_nxt;
  logic                    dv_r, dv_nxt;
  logic                    last_r, last_nxt;
  logic                    out_load;

  // Timer RAM: {reload_period, remaining_count}
  logic [2*TW-1:0]         tmr_mem [NUM_TIMERS];
  logic                    mem_wr_en;
  logic [IDX_W-1:0]        mem_wr_addr;
  logic [2*TW-1:0]         mem_wr_data;
  logic                    mem_rd_en;
  logic [IDX_W-1:0]        mem_rd_addr;
  logic [2*TW-1:0]         mem_rd_data_r;

  // Slot being updated
  logic [TW-1:0]           p_rem, p_reload, p_dec, p_new;
  logic                    p_run, p_per, p_zero, p_stay, p_exp, p_emit;
  logic                    out_free, stall;
  logic [IDX_W+2:0]        p_slot_ext, free_slot_ext;
  logic                    create_ok;
  logic                    fin_any;
  logic [TW-1:0]           fin_min;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_free   = !out_valid_r || out_tready;

  assign p_rem    = mem_rd_data_r[TW-1:0];
  assign p_reload = mem_rd_data_r[2*TW-1:TW];
  assign p_run    = running_r[p_idx_r];
  assign p_per    = periodic_r[p_idx_r];
  assign p_dec    = (el_r >= p_rem) ? '0 : (p_rem - el_r);
  assign p_zero   = (p_dec == '0);

  always_comb begin
    if (apply_r) begin
      p_new  = (p_zero && p_per) ? p_reload : p_dec;
      p_stay = p_run && !(p_zero && !p_per);
      p_exp  = p_run && p_zero;
    end else begin
      p_new  = p_rem;
      p_stay = p_run;
      p_exp  = 1'b0;
    end
  end

  assign p_emit = p_exp && (exp_cnt_r < EXP_CNT_W'(MAX_EXPIRY));
  assign stall  = p_vld_r && p_emit && !out_free;

  assign p_slot_ext    = {3'b000, p_idx_r};
  assign free_slot_ext = {3'b000, free_idx_r};
  assign create_ok     = (func_r == FUNC_CREATE) && apply_r;

  // Fold the newly loaded slot into the sweep minimum
  always_comb begin
    fin_any = any_r;
    fin_min = min_r;
    if (create_ok && (!any_r || ticks_r < min_r)) begin
      fin_any = 1'b1;
      fin_min = ticks_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    rd_cnt_nxt     = rd_cnt_r;
    p_vld_nxt      = p_vld_r;
    running_nxt    = running_r;
    periodic_nxt   = periodic_r;
    func_nxt       = func_r;
    apply_nxt      = apply_r;
    el_nxt         = el_r;
    ticks_nxt      = ticks_r;
    per_nxt        = per_r;
    id_nxt         = id_r;
    p_idx_nxt      = p_idx_r;
    exp_cnt_nxt    = exp_cnt_r;
    min_nxt        = min_r;
    any_nxt        = any_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    kind_nxt       = kind_r;
    slot_nxt       = slot_r;
    ok_nxt         = ok_r;
    dl_nxt         = dl_r;
    dv_nxt         = dv_r;
    last_nxt       = last_r;
    out_load       = 1'b0;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = p_idx_r;
    mem_wr_data    = {p_reload, p_new};
    mem_rd_en      = 1'b0;
    mem_rd_addr    = rd_cnt_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          func_nxt       = in_tuser;
          el_nxt         = in_elapsed[TW-1:0];
          ticks_nxt      = in_ticks;
          per_nxt        = in_periodic;
          id_nxt         = in_id;
          // full pool: sweep only for the deadline, leave the timers alone
          apply_nxt      = (in_tuser != FUNC_DESTROY) &&
                           !((in_tuser == FUNC_CREATE) && (&running_r));
          rd_cnt_nxt     = '0;
          p_vld_nxt      = 1'b0;
          exp_cnt_nxt    = '0;
          min_nxt        = '0;
          any_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = (in_tuser == FUNC_DESTROY) ? ST_FINAL : ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (!stall) begin
          if (p_vld_r) begin
            if (!p_run && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = p_idx_r;
            end
            mem_wr_en = apply_r && p_run;
            if (p_exp && !p_per) begin
              running_nxt[p_idx_r] = 1'b0;
            end
            if (p_stay && (!any_r || p_new < min_r)) begin
              min_nxt = p_new;
              any_nxt = 1'b1;
            end
            if (p_emit) begin
              out_load    = 1'b1;
              kind_nxt    = KIND_EXPIRED;
              slot_nxt    = p_slot_ext[2:0];
              ok_nxt      = 1'b0;
              dl_nxt      = '0;
              dv_nxt      = 1'b0;
              last_nxt    = 1'b0;
              exp_cnt_nxt = exp_cnt_r + EXP_CNT_W'(1);
            end
          end
          if (rd_cnt_r != END_CNT) begin
            mem_rd_en  = 1'b1;
            p_vld_nxt  = 1'b1;
            p_idx_nxt  = rd_cnt_r[IDX_W-1:0];
            rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
          end else begin
            p_vld_nxt = 1'b0;
            state_nxt = ST_FINAL;
          end
        end
      end

      ST_FINAL: begin
        if (out_free) begin
          out_load  = 1'b1;
          last_nxt  = 1'b1;
          state_nxt = ST_IDLE;
          if (func_r == FUNC_DESTROY) begin
            kind_nxt = KIND_DESTROY;
            slot_nxt = id_r;
            ok_nxt   = 1'b0;
            dl_nxt   = '0;
            dv_nxt   = 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
              if (i == int'(id_r)) begin
                running_nxt[i] = 1'b0;
              end
            end
          end else begin
            kind_nxt = (func_r == FUNC_CREATE) ? KIND_CREATE : KIND_UPDATE;
            slot_nxt = create_ok ? free_slot_ext[2:0] : 3'b000;
            ok_nxt   = create_ok;
            dl_nxt   = fin_any ? 32'(fin_min) : 32'd0;
            dv_nxt   = fin_any;
            if (create_ok) begin
              running_nxt[free_idx_r]  = 1'b1;
              periodic_nxt[free_idx_r] = per_r;
              mem_wr_en   = 1'b1;
              mem_wr_addr = free_idx_r;
              mem_wr_data = {ticks_r, ticks_r};
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= '0;
      p_vld_r     <= 1'b0;
      running_r   <= '0;
      periodic_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      p_vld_r     <= p_vld_nxt;
      running_r   <= running_nxt;
      periodic_r  <= periodic_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    apply_r      <= apply_nxt;
    el_r         <= el_nxt;
    ticks_r      <= ticks_nxt;
    per_r        <= per_nxt;
    id_r         <= id_nxt;
    p_idx_r      <= p_idx_nxt;
    exp_cnt_r    <= exp_cnt_nxt;
    min_r        <= min_nxt;
    any_r        <= any_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    kind_r       <= kind_nxt;
    slot_r       <= slot_nxt;
    ok_r         <= ok_nxt;
    dl_r         <= dl_nxt;
    dv_r         <= dv_nxt;
    last_r       <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      tmr_mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      mem_rd_data_r <= tmr_mem[mem_rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, dv_r, dl_r, ok_r, slot_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

/* hw/rtl/vtp_checker.sv */
// Port-level checks for virtual_timer_pool, bound to the top level.
// Depends on vtp_pkg and virtual_timer_pool_macros.svh.
`include "virtual_timer_pool_macros.svh"

module vtp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [vtp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [vtp_pkg::USER_W-1:0]     out_tuser,
  input logic                           out_tlast
);
  import vtp_pkg::*;

  // stalled result word holds
  `VTP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // no new request while a request still has words to deliver
  `VTP_ASSERT_SAME(a_busy_mid_run, out_tvalid && !out_tlast, !in_tready)

  // expiry words are never last and carry no status or deadline
  `VTP_ASSERT_SAME(a_expiry_fields, out_tvalid && (out_tuser == KIND_EXPIRED), !out_tlast && (out_tdata[OUT_DV_BIT:OUT_OK_BIT] == '0))

  // deadline reads zero unless flagged valid
  `VTP_ASSERT_SAME(a_deadline_zero, out_tvalid && !out_tdata[OUT_DV_BIT], out_tdata[OUT_DL_MSB:OUT_DL_LSB] == '0)

  // the block is busy in the cycle after it accepts a request
  `VTP_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, !in_tready)

endmodule

bind virtual_timer_pool vtp_checker u_vtp_checker (.*);
